// ----- design/swbm_pkg.sv -----
// Shared types and constants for the sliding-window bitrate monitor.
// Holds field widths, op and register codes, controller states and the
// command/status structs that join the controller and the datapath.
package swbm_pkg;

    localparam int MAX_SAMPLES_DEF = 64;

    localparam int OP_W      = 2;
    localparam int TIME_W    = 32;
    localparam int BYTES_W   = 20;
    localparam int THR_W     = 20;
    localparam int WIN_W     = 16;
    localparam int RATE_W    = 37;
    localparam int LIFE_W    = 48;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // bytes * 8 bits * 256 (Q8) = bytes << 11
    localparam int RATE_SHIFT = 11;
    localparam int FRAC_BITS  = 8;

    localparam int WIN_RESET = 1000;

    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 8'd1;

    typedef struct packed {
        logic [TIME_W-1:0]  t;
        logic [BYTES_W-1:0] b;
    } sample_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC_DROP,
        S_REC_WRITE,
        S_SETTLE,
        S_EVICT,
        S_DIV,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic drop;
        logic set_ovf;
        logic rec_write;
        logic clear;
        logic div_start;
        logic div_step;
        logic rate_zero;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic ring_full;
        logic ring_empty;
        logic evict_ok;
        logic span_pos;
        logic div_last;
        logic is_check;
    } sts_t;

endpackage

// ----- design/swbm_ctrl.sv -----
// Controller state machine of the bitrate monitor.
// Depends on swbm_pkg; drives datapath commands and both channel handshakes.
module swbm_ctrl
    import swbm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [OP_W-1:0] s_op,
    output logic            m_valid,
    input  logic            m_ready,
    input  sts_t            sts,
    output cmd_t            cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    unique case (s_op)
                        OP_RECORD: state_next = sts.ring_full ? S_REC_DROP : S_REC_WRITE;
                        OP_CHECK:  state_next = S_EVICT;
                        OP_CLEAR:  state_next = S_CLEAR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_REC_DROP: begin
                cmd.drop    = 1'b1;
                cmd.set_ovf = 1'b1;
                state_next  = S_REC_WRITE;
            end
            S_REC_WRITE: begin
                cmd.rec_write = 1'b1;
                state_next    = S_SETTLE;
            end
            S_SETTLE: begin
                state_next = S_EVICT;
            end
            S_EVICT: begin
                if (sts.evict_ok) begin
                    cmd.drop = 1'b1;
                end else if (sts.ring_empty) begin
                    cmd.rate_zero = sts.is_check;
                    state_next    = S_DONE;
                end else if (sts.span_pos) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- design/swbm_dpath.sv -----
// Datapath of the bitrate monitor: sample ring memory, window and lifetime
// sums, bit-serial rate divider, config registers and result register.
// Depends on swbm_pkg; commanded by swbm_ctrl.
module swbm_dpath
    import swbm_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [OP_W-1:0]      s_op,
    input  logic [TIME_W-1:0]    s_time_ms,
    input  logic [BYTES_W-1:0]   s_byte_count,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic [RATE_W-1:0]    m_rate_kbps_q8,
    output logic                 m_is_low,
    output logic [LIFE_W-1:0]    m_lifetime_bytes,
    output logic                 m_ring_overflow
);

    localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = BYTES_W + CNT_W;
    localparam int NUM_W  = SUM_W + RATE_SHIFT;
    localparam int QX_W   = (NUM_W > RATE_W) ? NUM_W : RATE_W;
    localparam int BCNT_W = $clog2(NUM_W + 1);
    localparam int REM_W  = TIME_W + 1;

    sample_t ring_mem [MAX_SAMPLES];

    logic [OP_W-1:0]    op_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [WIN_W-1:0]   win_reg;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LIFE_W-1:0]  life_reg, life_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               ovf_reg;
    sample_t            rd_data_reg;

    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [TIME_W-1:0]  den_reg;
    logic [BCNT_W-1:0]  bcnt_reg;

    logic [RATE_W-1:0]  out_rate_reg;
    logic               out_low_reg;
    logic [LIFE_W-1:0]  out_life_reg;
    logic               out_ovf_reg;

    logic [IDX_W-1:0]   head_inc;
    logic [IDX_W:0]     tail_wide;
    logic [IDX_W-1:0]   tail;
    logic [LIFE_W:0]    life_add;
    logic [REM_W-1:0]   rem_sh;
    logic               q_bit;
    logic [QX_W-1:0]    quo_ext;
    logic [TIME_W:0]    evict_lhs;

    // ring indexing
    assign head_inc  = (head_reg == IDX_W'(MAX_SAMPLES - 1)) ? '0 : head_reg + 1'b1;
    assign tail_wide = {1'b0, head_reg} + (IDX_W + 1)'(cnt_reg);
    assign tail      = (tail_wide >= (IDX_W + 1)'(MAX_SAMPLES))
                     ? IDX_W'(tail_wide - (IDX_W + 1)'(MAX_SAMPLES))
                     : tail_wide[IDX_W-1:0];

    // sample older than now - window, done in 33 bits so the cutoff never wraps
    assign evict_lhs = {1'b0, rd_data_reg.t} + (TIME_W + 1)'(win_reg);

    assign sts.ring_full  = (cnt_reg == CNT_W'(MAX_SAMPLES));
    assign sts.ring_empty = (cnt_reg == '0);
    assign sts.evict_ok   = (cnt_reg != '0) && (evict_lhs < {1'b0, now_reg});
    assign sts.span_pos   = (now_reg > rd_data_reg.t);
    assign sts.div_last   = (bcnt_reg == BCNT_W'(1));
    assign sts.is_check   = (op_reg == OP_CHECK);

    // restoring division, one quotient bit per cycle
    assign rem_sh   = {rem_reg[REM_W-2:0], quo_reg[NUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, den_reg});
    assign rem_next = q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;
    assign quo_next = {quo_reg[NUM_W-2:0], q_bit};
    assign quo_ext  = QX_W'(quo_next);

    assign life_add = {1'b0, life_reg} + (LIFE_W + 1)'(bytes_reg);

    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        life_next = life_reg;
        rate_next = rate_reg;
        if (cmd.clear) begin
            head_next = '0;
            cnt_next  = '0;
            sum_next  = '0;
            life_next = '0;
            rate_next = '0;
        end
        if (cmd.drop) begin
            head_next = head_inc;
            cnt_next  = cnt_reg - 1'b1;
            sum_next  = sum_reg - SUM_W'(rd_data_reg.b);
        end
        if (cmd.rec_write) begin
            cnt_next  = cnt_reg + 1'b1;
            sum_next  = sum_reg + SUM_W'(bytes_reg);
            life_next = life_add[LIFE_W] ? '1 : life_add[LIFE_W-1:0];
        end
        if (cmd.rate_zero) begin
            rate_next = '0;
        end
        if (cmd.div_step && sts.div_last) begin
            // saturate when the quotient overflows the rate field
            rate_next = (|(quo_ext >> RATE_W)) ? '1 : quo_ext[RATE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= '0;
            win_reg  <= WIN_W'(WIN_RESET);
            head_reg <= '0;
            cnt_reg  <= '0;
            sum_reg  <= '0;
            life_reg <= '0;
            rate_reg <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_index)
                    REG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    REG_WINDOW:    win_reg <= cfg_data[WIN_W-1:0];
                    default:       ;
                endcase
            end
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            life_reg <= life_next;
            rate_reg <= rate_next;
        end
    end

    // ring memory: one write port, one registered read port tracking the head
    always_ff @(posedge aclk) begin
        if (cmd.rec_write) begin
            ring_mem[tail] <= '{t: now_reg, b: bytes_reg};
        end
        rd_data_reg <= ring_mem[head_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg    <= s_op;
            now_reg   <= s_time_ms;
            bytes_reg <= s_byte_count;
            ovf_reg   <= 1'b0;
        end else if (cmd.set_ovf) begin
            ovf_reg <= 1'b1;
        end
        if (cmd.div_start) begin
            quo_reg  <= NUM_W'(sum_reg) << RATE_SHIFT;
            rem_reg  <= '0;
            den_reg  <= now_reg - rd_data_reg.t;
            bcnt_reg <= BCNT_W'(NUM_W);
        end else if (cmd.div_step) begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            bcnt_reg <= bcnt_reg - 1'b1;
        end
        if (cmd.load_out) begin
            out_rate_reg <= rate_reg;
            out_low_reg  <= (op_reg == OP_CHECK) && (cnt_reg != '0)
                         && (rate_reg < RATE_W'({thr_reg, {FRAC_BITS{1'b0}}}));
            out_life_reg <= life_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_rate_kbps_q8   = out_rate_reg;
    assign m_is_low         = out_low_reg;
    assign m_lifetime_bytes = out_life_reg;
    assign m_ring_overflow  = out_ovf_reg;

endmodule

// ----- design/sliding_window_bitrate_monitor_top.sv -----
// Top level of the sliding-window bitrate monitor.
// Depends on swbm_pkg, swbm_ctrl and swbm_dpath.
//
// Usage:
//   s_* is the event channel (op, time_ms, byte_count); m_* returns exactly
//   one result per event: rate in kbps Q8, low flag, lifetime bytes and the
//   ring overflow flag. cfg_* writes threshold_kbps (index 0) and window_ms
//   (index 1); other indexes are dropped. cfg_ready is always high; write
//   only while no event is in flight.
//   One event at a time; s_ready is high only while idle, so the next event
//   is accepted only once the result of the last one has been loaded.
//   Steps per event, from accept to result loaded:
//     record: drop (only if the ring was full), write, settle, evict, divide
//     check:  evict, divide
//     clear: clear, unused op: straight to the result
//   where evict drops samples one per cycle (set by the single read port of
//   the sample ring) and divide runs the bit-serial divider for a NUM_W = 38
//   bit quotient at 64 samples, only when a new rate is computed.
//   A result waits in the output register while m_ready is low; the next
//   event may be accepted meanwhile, but its own result is held back until
//   the output register frees up.
//   Reset clears the ring pointers, sums, rate and config registers (window 1000);
//   the sample memory needs no clearing pass, only live entries are read.
module sliding_window_bitrate_monitor_top
    import swbm_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // event channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_op,
    input  logic [TIME_W-1:0]    s_time_ms,
    input  logic [BYTES_W-1:0]   s_byte_count,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [RATE_W-1:0]    m_rate_kbps_q8,
    output logic                 m_is_low,
    output logic [LIFE_W-1:0]    m_lifetime_bytes,
    output logic                 m_ring_overflow,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // config transfers complete every cycle
    assign cfg_ready = 1'b1;

    // controller: sequences drop, write, eviction walk, divide, clear and result
    swbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: ring, sums, divider, config and output registers
    swbm_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_op             (s_op),
        .s_time_ms        (s_time_ms),
        .s_byte_count     (s_byte_count),
        .cfg_wr           (cfg_valid & cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_rate_kbps_q8   (m_rate_kbps_q8),
        .m_is_low         (m_is_low),
        .m_lifetime_bytes (m_lifetime_bytes),
        .m_ring_overflow  (m_ring_overflow)
    );

`ifndef NO_ASSERTIONS
    // an accepted event keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after an event transfer");

    // a new result is loaded only from the finishing state, never from idle
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while controller was idle");

    // overflow comes only from a record, low only from a check
    a_ovf_low_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ring_overflow |-> !m_is_low)
        else $error("overflow and low flagged on the same result");
`endif

endmodule

// ----- tb/sv/swbm_result_checker.sv -----
// Result checker for the sliding-window bitrate monitor test.
// Watches the event, result and register-write channels, keeps its own copy of
// the monitor state and compares every result transfer. Depends on swbm_pkg.
module swbm_result_checker
    import swbm_pkg::*;
#(
    parameter int DEPTH = MAX_SAMPLES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [OP_W-1:0]      s_op,
    input  logic [TIME_W-1:0]    s_time_ms,
    input  logic [BYTES_W-1:0]   s_byte_count,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [RATE_W-1:0]    m_rate_kbps_q8,
    input  logic                 m_is_low,
    input  logic [LIFE_W-1:0]    m_lifetime_bytes,
    input  logic                 m_ring_overflow,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatch_count,
    output int                   pending,
    output int                   compared,
    output int                   overflows_seen,
    output int                   lows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [RATE_W-1:0] RATE_CAP = '1;
    localparam logic [LIFE_W-1:0] LIFE_CAP = '1;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              low;
        logic [LIFE_W-1:0] life;
        logic              ovf;
    } rate_report_t;

    logic [THR_W-1:0]  thr_kbps;
    logic [WIN_W-1:0]  win_ms;
    sample_t           ring [DEPTH];
    int unsigned       head;
    int unsigned       count;
    logic [63:0]       win_bytes;
    logic [63:0]       life_bytes;
    logic [RATE_W-1:0] rate_q8;
    rate_report_t      expected_q [$];

    function automatic void retire_oldest();
        win_bytes = win_bytes - ring[head].b;
        head = (head + 1) % DEPTH;
        count = count - 1;
    endfunction

    // Age out samples older than now minus window; refresh rate if span > 0.
    function automatic void age_out(input logic [TIME_W-1:0] now);
        longint      cutoff;
        longint      oldest;
        longint      span;
        logic [63:0] quot;
        cutoff = {32'd0, now};
        cutoff = cutoff - longint'({48'd0, win_ms});
        oldest = 0;
        while (count > 0) begin
            oldest = {32'd0, ring[head].t};
            if (oldest >= cutoff)
                break;
            retire_oldest();
        end
        if (count == 0)
            return;
        span = {32'd0, now};
        span = span - oldest;
        if (span > 0) begin
            quot = (win_bytes << RATE_SHIFT) / 64'(span);
            rate_q8 = (quot > RATE_CAP) ? RATE_CAP : quot[RATE_W-1:0];
        end
    endfunction

    function automatic rate_report_t predict_event(input logic [OP_W-1:0]    op,
                                                   input logic [TIME_W-1:0]  now,
                                                   input logic [BYTES_W-1:0] nbytes);
        rate_report_t r;
        int unsigned  tail;
        r = '0;
        case (op)
            OP_RECORD: begin
                if (count >= DEPTH) begin
                    retire_oldest();
                    r.ovf = 1'b1;
                end
                tail = (head + count) % DEPTH;
                ring[tail].t = now;
                ring[tail].b = nbytes;
                count = count + 1;
                win_bytes = win_bytes + nbytes;
                life_bytes = life_bytes + nbytes;
                if (life_bytes > LIFE_CAP)
                    life_bytes = LIFE_CAP;
                age_out(now);
            end
            OP_CHECK: begin
                age_out(now);
                if (count == 0)
                    rate_q8 = '0;
                else
                    r.low = (rate_q8 < {thr_kbps, {FRAC_BITS{1'b0}}});
            end
            OP_CLEAR: begin
                head = 0;
                count = 0;
                win_bytes = '0;
                life_bytes = '0;
                rate_q8 = '0;
            end
            default: ;
        endcase
        r.rate = rate_q8;
        r.life = life_bytes[LIFE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 200)
            $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h",
                     $realtime, compared, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        rate_report_t want;
        if (!aresetn) begin
            thr_kbps = '0;
            win_ms = WIN_W'(WIN_RESET);
            head = 0;
            count = 0;
            win_bytes = '0;
            life_bytes = '0;
            rate_q8 = '0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                compared++;
                if (m_ring_overflow)
                    overflows_seen++;
                if (m_is_low)
                    lows_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("transfer with nothing expected, rate",
                                    64'(m_rate_kbps_q8), '0);
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (m_rate_kbps_q8 !== want.rate)
                        report_mismatch("rate_kbps_q8", 64'(m_rate_kbps_q8), 64'(want.rate));
                    if (m_is_low !== want.low)
                        report_mismatch("is_low", 64'(m_is_low), 64'(want.low));
                    if (m_lifetime_bytes !== want.life)
                        report_mismatch("lifetime_bytes", 64'(m_lifetime_bytes),
                                        64'(want.life));
                    if (m_ring_overflow !== want.ovf)
                        report_mismatch("ring_overflow", 64'(m_ring_overflow), 64'(want.ovf));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: thr_kbps = cfg_data[THR_W-1:0];
                    REG_WINDOW:    win_ms = cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.insert(expected_q.size(),
                                  predict_event(s_op, s_time_ms, s_byte_count));
        end
        pending <= expected_q.size();
    end

endmodule

// ----- tb/sv/sliding_window_bitrate_monitor_top_test.sv -----
// Top of the sliding-window bitrate monitor test: clock, reset, event and
// register-write stimulus, result-side pacing and the verdict.
// Depends on swbm_pkg, the monitor RTL and swbm_result_checker.
module sliding_window_bitrate_monitor_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swbm_pkg::*;

    // The package names no code for the fourth op; the block must hold state on it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Slowest event: a record into a full ring that drops, walks the evictions and divides.
    localparam int DRAIN_CYCLES = 120;
    localparam int LONG_HOLD    = 400;
    localparam int LEG_EVENTS   = 48;
    localparam int CYCLE_LIMIT  = 600000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op = OP_RECORD;
    logic [TIME_W-1:0]    s_time_ms = '0;
    logic [BYTES_W-1:0]   s_byte_count = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [RATE_W-1:0]    m_rate_kbps_q8;
    logic                 m_is_low;
    logic [LIFE_W-1:0]    m_lifetime_bytes;
    logic                 m_ring_overflow;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int mismatch_count;
    int pending;
    int compared;
    int overflows_seen;
    int lows_seen;

    // Pacing knobs; the receiver ones are read by their own process, so
    // write them with nonblocking assignments at the clock edge.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int unsigned cycles = 0;

    // Stimulus bookkeeping.
    logic [TIME_W-1:0] clock_ms = '0;
    int                win_cfg = WIN_RESET;
    int                op_tally [4];

    sliding_window_bitrate_monitor_top dut (.*);

    swbm_result_checker scoreboard (
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .compared       (compared),
        .overflows_seen (overflows_seen),
        .lows_seen      (lows_seen),
        .*
    );

    always #6 aclk = ~aclk;

    // Bound the run; a hung handshake ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result-side pacing. A long hold-off is counted here, so the stimulus
    // can keep offering events while the output register stays blocked.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one event and hold it until the transfer. Valid stays high on
    // return; the caller either offers the next event in the same step or
    // drops valid, so a transfer is never repeated.
    task automatic send_event(input logic [OP_W-1:0]    op,
                              input logic [TIME_W-1:0]  t,
                              input logic [BYTES_W-1:0] nbytes);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_time_ms    <= t;
        s_byte_count <= nbytes;
        do @(posedge aclk); while (!s_ready);
        op_tally[op]++;
    endtask

    // Drop valid and wait until every expected result has been transferred.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Program both registers, then poke an index past the last register,
    // which must change nothing. Call only with no event in flight.
    task automatic set_regs(input logic [CFG_DAT_W-1:0] thr_word,
                            input logic [CFG_DAT_W-1:0] win_word);
        write_reg(REG_THRESHOLD, thr_word);
        write_reg(REG_WINDOW, win_word);
        write_reg(CFG_IDX_W'($urandom_range(255, 2)), $urandom);
        cfg_valid <= 1'b0;
        win_cfg = win_word[WIN_W-1:0];
    endtask

    // Random traffic in bursts. Each burst fixes a time pacing relative to
    // the window and a byte scale; fill bursts are back-to-back records that
    // overrun the ring. Bursts may start at a fresh time base: anywhere,
    // near zero (cutoff below zero) or near the top (timestamp wrap).
    task automatic random_events(input int total);
        int                 sent;
        int                 burst_left;
        int                 step_max;
        int                 r;
        bit                 fill_burst;
        bit                 small_bytes;
        logic [OP_W-1:0]    op;
        logic [TIME_W-1:0]  t;
        logic [BYTES_W-1:0] nbytes;
        sent = 0;
        burst_left = 0;
        step_max = 1;
        fill_burst = 1'b0;
        small_bytes = 1'b0;
        while (sent < total) begin
            if (burst_left == 0) begin
                r = $urandom_range(99);
                fill_burst = (r < 10);
                if (fill_burst) begin
                    burst_left = $urandom_range(90, 66);
                    step_max = 1;
                end else begin
                    burst_left = $urandom_range(60, 4);
                    if (r < 35)
                        step_max = 2;
                    else if (r < 60)
                        step_max = win_cfg / 16 + 1;
                    else if (r < 85)
                        step_max = win_cfg / 2 + 1;
                    else
                        step_max = win_cfg * 2 + 1;
                end
                small_bytes = ($urandom_range(1) != 0);
                r = $urandom_range(99);
                if (r < 12)
                    clock_ms = $urandom;
                else if (r < 18)
                    clock_ms = $urandom_range(60);
                else if (r < 22)
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
            end
            clock_ms = clock_ms + $urandom_range(step_max);
            t = clock_ms;
            r = $urandom_range(99);
            if (fill_burst || r < 68) begin
                op = OP_RECORD;
            end else if (r < 88) begin
                op = OP_CHECK;
            end else if (r < 91) begin
                op = OP_CLEAR;
            end else if (r < 94) begin
                op = OP_UNUSED;
            end else begin
                // step back in time, behind some or all held samples
                op = (r < 97) ? OP_RECORD : OP_CHECK;
                t = clock_ms - $urandom_range(win_cfg + 8);
            end
            r = $urandom_range(99);
            if (r < 4)
                nbytes = '1;
            else if (r < 8)
                nbytes = '0;
            else if (small_bytes)
                nbytes = BYTES_W'($urandom_range(2047));
            else
                nbytes = BYTES_W'($urandom);
            send_event(op, t, nbytes);
            sent++;
            burst_left--;
        end
    endtask

    initial begin
        // Hold reset, then release it at a clock edge.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 8;
        recv_idle_pct <= 64;

        // Directed part, reset registers: threshold 0, window 1000.
        send_event(OP_CHECK, 32'd0, 20'd0);             // empty window: rate 0, not low
        send_event(OP_RECORD, 32'd0, 20'd0);            // zero span: rate held
        send_event(OP_RECORD, 32'd0, 20'hF_FFFF);
        send_event(OP_RECORD, 32'd40, 20'd12345);       // cutoff below zero keeps all
        send_event(OP_CHECK, 32'd40, 20'd0);
        send_event(OP_UNUSED, 32'hFFFF_FFFF, 20'hF_FFFF); // no state change
        send_event(OP_CHECK, 32'd20, 20'd0);            // time runs backward
        send_event(OP_CHECK, 32'd1040, 20'd0);          // evict the samples at time zero
        send_event(OP_CHECK, 32'd5000, 20'd0);          // window empties: rate 0
        send_event(OP_RECORD, 32'd5000, 20'd777);
        send_event(OP_CHECK, 32'd4000, 20'd0);          // only sample is newer than now
        send_event(OP_CLEAR, 32'd5000, 20'hF_FFFF);
        send_event(OP_RECORD, 32'hFFFF_FFFF, 20'hF_FFFF);
        send_event(OP_CHECK, 32'hFFFF_FFFF, 20'd0);
        wait_for_results();

        // Window of zero, top threshold: evict only strictly older samples.
        set_regs(32'hFFFF_FFFF, 32'd0);
        send_event(OP_RECORD, 32'd100, 20'd500);
        send_event(OP_RECORD, 32'd100, 20'd600);
        send_event(OP_RECORD, 32'd101, 20'd1);
        send_event(OP_CHECK, 32'd101, 20'd0);           // low against the top threshold
        wait_for_results();

        // Widest window, threshold one: fast rate from a one-millisecond span.
        set_regs(32'd1, 32'hFFFF_FFFF);
        send_event(OP_RECORD, 32'd10, 20'hF_FFFF);
        send_event(OP_RECORD, 32'd11, 20'hF_FFFF);
        send_event(OP_CHECK, 32'd12, 20'd0);
        wait_for_results();

        // Random part in three pacing phases: sender idles lightly and
        // receiver heavily, then the reverse, then neither idles.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 64 : 0;
            recv_idle_pct <= (phase == 0) ? 64 : (phase == 1) ? 8 : 0;
            for (int leg = 0; leg < 3; leg++) begin
                wait_for_results();
                if (leg == 0)
                    set_regs($urandom, $urandom_range(4000, 20));
                else if (leg == 1 && phase == 0)
                    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                else if (leg == 1 && phase == 1)
                    set_regs(32'd0, 32'd1);
                else if (leg == 1)
                    set_regs($urandom_range(4096), 32'hFFFF_FFFF);
                else
                    set_regs($urandom_range(32'h1_0000), $urandom);
                // Block the result channel for a long stretch while events
                // keep coming, so the block fills and stalls its input.
                if (phase == 2 && leg == 1)
                    hold_requests <= hold_requests + 1;
                random_events(LEG_EVENTS);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Events sent: %0d records, %0d checks, %0d clears, %0d of the unused op",
                 op_tally[OP_RECORD], op_tally[OP_CHECK], op_tally[OP_CLEAR],
                 op_tally[OP_UNUSED]);
        $display("Results compared: %0d, %0d with ring overflow, %0d flagged low",
                 compared, overflows_seen, lows_seen);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
